// File: hw/rtl/abbx_pkg.sv
package abbx_pkg;

   localparam int DIM_W      = 13;
   localparam int ALPHA_W    = 8;
   localparam int EXTENT_W   = 17;
   localparam int BOX_MAX_W  = 12;
   localparam int CSR_ADDR_W = 1;
   localparam int RSP_PAD_W  = 2;
   localparam int RSP_DATA_W = 4 * EXTENT_W + 2 * DIM_W + 2 * BOX_MAX_W + RSP_PAD_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 13'd64;

   typedef struct packed {
      logic frame_end;
      logic all_clear;
   } trk_status_type;

endpackage

// File: hw/rtl/abbx_tracker.sv
module abbx_tracker
   import abbx_pkg::*;
#(
   parameter int MAX_DIM = 4096,
   parameter int CNT_W   = $clog2(MAX_DIM),
   parameter int SIZE_W  = $clog2(MAX_DIM + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pix_accept,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [SIZE_W-1:0]  width_eff,
   input  logic [SIZE_W-1:0]  height_eff,
   output trk_status_type     status,
   output logic [SIZE_W-1:0]  box_min_col,
   output logic [CNT_W-1:0]   box_max_col,
   output logic [SIZE_W-1:0]  box_min_row,
   output logic [CNT_W-1:0]   box_max_row
);

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic              seen_ff, seen_in;
   logic [SIZE_W-1:0] min_col_ff, min_col_in;
   logic [CNT_W-1:0]  max_col_ff, max_col_in;
   logic [SIZE_W-1:0] min_row_ff, min_row_in;
   logic [CNT_W-1:0]  max_row_ff, max_row_in;
   logic [SIZE_W-1:0] col_wide, row_wide, col_sum, row_sum;
   logic              colored, row_end, frame_end;

   always_comb begin
      colored  = |alpha;
      col_wide = SIZE_W'(col_ff);
      row_wide = SIZE_W'(row_ff);
      col_sum  = col_wide + SIZE_W'(1);
      row_sum  = row_wide + SIZE_W'(1);
      row_end  = (col_sum >= width_eff);
      frame_end = row_end && (row_sum >= height_eff);

      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      if (colored && !seen_ff) begin
         min_col_in = col_wide;
         max_col_in = col_ff;
         min_row_in = row_wide;
         max_row_in = row_ff;
      end else if (colored) begin
         if (col_wide < min_col_ff) min_col_in = col_wide;
         if (col_ff > max_col_ff)   max_col_in = col_ff;
         if (row_wide < min_row_ff) min_row_in = row_wide;
         if (row_ff > max_row_ff)   max_row_in = row_ff;
      end

      // box including the current pixel; start values when nothing colored
      if (seen_ff || colored) begin
         box_min_col = min_col_in;
         box_max_col = max_col_in;
         box_min_row = min_row_in;
         box_max_row = max_row_in;
      end else begin
         box_min_col = width_eff;
         box_max_col = '0;
         box_min_row = height_eff;
         box_max_row = '0;
      end
      status.frame_end = frame_end;
      status.all_clear = !(seen_ff || colored);

      col_in  = row_end ? '0 : col_sum[CNT_W-1:0];
      row_in  = row_ff;
      seen_in = seen_ff || colored;
      if (row_end) begin
         row_in = frame_end ? '0 : row_sum[CNT_W-1:0];
      end
      if (frame_end) begin
         seen_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= 1'b0;
      end else if (pix_accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         seen_ff <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
      end
   end

endmodule

// File: hw/rtl/abbx_divider.sv
module abbx_divider
   import abbx_pkg::*;
#(
   parameter int DEN_W     = 13,
   parameter int FRAC_BITS = 16,
   parameter int NUM_W     = DEN_W + FRAC_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] numer_hi,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      fits    = !diff[DEN_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = denom;
         quo_in  = {numer_hi, {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         // one restoring step: shift in the next dividend bit, subtract if it fits
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1) && !start) |=> (done_ff && !busy_ff))
      else $error("divider did not finish after last step");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

// File: hw/rtl/alpha_bounding_box_extents_unit.sv
// Pixels are taken one per cycle while a frame is tracked.
// After the last pixel of a frame the four extents are divided one after another on
// one restoring divider, one quotient bit per cycle, and no pixel is taken until the
// result sits in the output register.
// Synchronous active-high reset: sizes return to 64 x 64, tracking restarts, no result pending.
module alpha_bounding_box_extents_unit
   import abbx_pkg::*;
#(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ALPHA_W-1:0]    req_tdata,   // [7:0] alpha
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [16:0] left_extent, [33:17] right_extent, [50:34] top_extent,
   // [67:51] bottom_extent, [80:68] box_min_col, [92:81] box_max_col,
   // [105:93] box_min_row, [117:106] box_max_row, [119:118] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // [0] all_clear
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_DIM);
   localparam int SIZE_W = $clog2(MAX_DIM + 1);
   localparam int NUM_W  = SIZE_W + FRAC_BITS;
   localparam int QS_W   = FRAC_BITS + 1;
   localparam int EXT_W  = FRAC_BITS + 2;

   localparam logic [NUM_W-1:0] Q_LIM = NUM_W'(1) << FRAC_BITS;
   localparam logic [EXT_W-1:0] HALF  =
      {{(EXT_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

   localparam logic [1:0] ST_TRACK = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   localparam logic [1:0] DIV_LEFT   = 2'd0;
   localparam logic [1:0] DIV_RIGHT  = 2'd1;
   localparam logic [1:0] DIV_TOP    = 2'd2;
   localparam logic [1:0] DIV_BOTTOM = 2'd3;

   logic [DIM_W-1:0]      width_ff, height_ff;
   logic [SIZE_W-1:0]     width_eff, height_eff;
   logic                  pix_accept;
   trk_status_type        trk_status;
   logic [SIZE_W-1:0]     trk_min_col, trk_min_row;
   logic [CNT_W-1:0]      trk_max_col, trk_max_row;
   logic [SIZE_W-1:0]     cap_min_col_ff, cap_min_row_ff;
   logic [CNT_W-1:0]      cap_max_col_ff, cap_max_row_ff;
   logic                  cap_clear_ff;
   logic [1:0]            state_ff, state_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  div_start, div_busy, div_done;
   logic [SIZE_W-1:0]     div_numer, div_denom;
   logic [NUM_W-1:0]      div_quot;
   logic [QS_W-1:0]       q_sat;
   logic [QS_W-1:0]       qsat_ff [4];
   logic                  load_rsp;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_clear_ff;
   logic signed [EXT_W-1:0] left_s, right_s, top_s, bottom_s;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero acts as one, saturate at MAX_DIM
   always_comb begin
      if (width_ff == '0) width_eff = SIZE_W'(1);
      else if (32'(width_ff) > MAX_DIM) width_eff = SIZE_W'(MAX_DIM);
      else width_eff = SIZE_W'(width_ff);
   end

   always_comb begin
      if (height_ff == '0) height_eff = SIZE_W'(1);
      else if (32'(height_ff) > MAX_DIM) height_eff = SIZE_W'(MAX_DIM);
      else height_eff = SIZE_W'(height_ff);
   end

   assign req_tready = (state_ff == ST_TRACK);
   assign pix_accept = req_tvalid && req_tready;

   abbx_tracker #(
      .MAX_DIM (MAX_DIM),
      .CNT_W   (CNT_W),
      .SIZE_W  (SIZE_W)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .pix_accept  (pix_accept),
      .alpha       (req_tdata),
      .width_eff   (width_eff),
      .height_eff  (height_eff),
      .status      (trk_status),
      .box_min_col (trk_min_col),
      .box_max_col (trk_max_col),
      .box_min_row (trk_min_row),
      .box_max_row (trk_max_row)
   );

   // hold the finished box while the divisions run
   always_ff @(posedge clock) begin
      if (pix_accept && trk_status.frame_end) begin
         cap_min_col_ff <= trk_min_col;
         cap_max_col_ff <= trk_max_col;
         cap_min_row_ff <= trk_min_row;
         cap_max_row_ff <= trk_max_row;
         cap_clear_ff   <= trk_status.all_clear;
      end
   end

   always_comb begin
      case (idx_ff)
         DIV_LEFT: begin
            div_numer = cap_min_col_ff;
            div_denom = width_eff;
         end
         DIV_RIGHT: begin
            div_numer = SIZE_W'(cap_max_col_ff) + SIZE_W'(1);
            div_denom = width_eff;
         end
         DIV_TOP: begin
            div_numer = cap_min_row_ff;
            div_denom = height_eff;
         end
         default: begin
            div_numer = SIZE_W'(cap_max_row_ff) + SIZE_W'(1);
            div_denom = height_eff;
         end
      endcase
   end

   assign div_start = (state_ff == ST_ISSUE);

   abbx_divider #(
      .DEN_W     (SIZE_W),
      .FRAC_BITS (FRAC_BITS),
      .NUM_W     (NUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer_hi (div_numer),
      .denom    (div_denom),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot)
   );

   // clamp the quotient to one; the extents then stay within plus or minus one half
   assign q_sat = (div_quot > Q_LIM) ? QS_W'(Q_LIM) : QS_W'(div_quot);

   always_ff @(posedge clock) begin
      if (div_done) begin
         qsat_ff[idx_ff] <= q_sat;
      end
   end

   assign load_rsp = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_TRACK: begin
            if (pix_accept && trk_status.frame_end) begin
               state_in = ST_ISSUE;
               idx_in   = DIV_LEFT;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               if (idx_ff == DIV_BOTTOM) begin
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_ISSUE;
                  idx_in   = idx_ff + 2'd1;
               end
            end
         end
         ST_HOLD: begin
            if (load_rsp) state_in = ST_TRACK;
         end
         default: state_in = ST_TRACK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TRACK;
         idx_ff       <= DIV_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      left_s   = signed'(HALF - EXT_W'(qsat_ff[DIV_LEFT]));
      right_s  = signed'(EXT_W'(qsat_ff[DIV_RIGHT]) - HALF);
      top_s    = signed'(HALF - EXT_W'(qsat_ff[DIV_TOP]));
      bottom_s = signed'(EXT_W'(qsat_ff[DIV_BOTTOM]) - HALF);
      rsp_data_in = {
         {RSP_PAD_W{1'b0}},
         BOX_MAX_W'(cap_max_row_ff),
         DIM_W'(cap_min_row_ff),
         BOX_MAX_W'(cap_max_col_ff),
         DIM_W'(cap_min_col_ff),
         EXTENT_W'(bottom_s),
         EXTENT_W'(top_s),
         EXTENT_W'(right_s),
         EXTENT_W'(left_s)
      };
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_clear_ff <= cap_clear_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_clear_ff;

   a_frame_end_issues: assert property (@(posedge clock) disable iff (reset)
      (pix_accept && trk_status.frame_end) |=> (state_ff == ST_ISSUE && idx_ff == DIV_LEFT))
      else $error("frame end did not start the divisions");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_WAIT))
      else $error("quotient arrived outside the wait state");

   a_wait_divider_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");

   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_tvalid && state_ff == ST_TRACK))
      else $error("loaded result not presented");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import abbx_pkg::*;

   localparam int MAX_DIM       = 4096;
   localparam int FRAC_BITS     = 16;
   localparam int HALF          = 1 << (FRAC_BITS - 1);
   localparam int SETTLE_CYCLES = 160;

   localparam logic [EXTENT_W-1:0] EXT_POS_HALF = 17'h08000;
   localparam logic [EXTENT_W-1:0] EXT_NEG_HALF = 17'h18000;
   localparam logic [EXTENT_W-1:0] EXT_ZERO     = 17'h00000;

   typedef struct packed {
      logic [EXTENT_W-1:0]  left_ext;
      logic [EXTENT_W-1:0]  right_ext;
      logic [EXTENT_W-1:0]  top_ext;
      logic [EXTENT_W-1:0]  bottom_ext;
      logic [DIM_W-1:0]     min_col;
      logic [BOX_MAX_W-1:0] max_col;
      logic [DIM_W-1:0]     min_row;
      logic [BOX_MAX_W-1:0] max_row;
      logic                 all_clear;
   } box_result_type;

   typedef enum logic [1:0] {
      OP_WIDTH,
      OP_HEIGHT,
      OP_PIXEL
   } row_op_type;

   typedef struct packed {
      row_op_type       op;
      logic [DIM_W-1:0] value;
      logic             typed;
      box_result_type   result;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [ALPHA_W-1:0]    req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [DIM_W-1:0]      csr_wdata;

   int tx_idle_pct;
   int rx_stall_pct;
   int mismatches = 0;
   bit need_settle;

   box_result_type pending_boxes[$];
   stim_row_type   directed_rows[$];

   // predictor state
   logic [DIM_W-1:0] cfg_width;
   logic [DIM_W-1:0] cfg_height;
   int col_cnt, row_cnt;
   int trk_min_col, trk_max_col, trk_min_row, trk_max_row;
   bit trk_seen;

   alpha_bounding_box_extents_unit #(
      .MAX_DIM   (MAX_DIM),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic void restart_tracking();
      col_cnt     = 0;
      row_cnt     = 0;
      trk_min_col = eff_dim(cfg_width);
      trk_max_col = 0;
      trk_min_row = eff_dim(cfg_height);
      trk_max_row = 0;
      trk_seen    = 1'b0;
   endfunction

   // near side: half - num/size, far side: num/size - half, clamped to +-half
   function automatic logic [EXTENT_W-1:0] extent(input longint num, input longint size,
                                                  input bit far_side);
      longint q, v;
      q = (num << FRAC_BITS) / size;
      v = far_side ? q - HALF : HALF - q;
      if (v > HALF) v = HALF;
      if (v < -HALF) v = -HALF;
      return v[EXTENT_W-1:0];
   endfunction

   function automatic bit track_pixel(input logic [ALPHA_W-1:0] alpha,
                                      output box_result_type res);
      int w, h, col, row, mnc, mxc, mnr, mxr;
      w   = eff_dim(cfg_width);
      h   = eff_dim(cfg_height);
      col = col_cnt;
      row = row_cnt;
      res = '0;
      if (alpha != 0) begin
         if (!trk_seen) begin
            trk_min_col = col;
            trk_max_col = col;
            trk_min_row = row;
            trk_max_row = row;
            trk_seen    = 1'b1;
         end else begin
            if (col < trk_min_col) trk_min_col = col;
            if (col > trk_max_col) trk_max_col = col;
            if (row < trk_min_row) trk_min_row = row;
            if (row > trk_max_row) trk_max_row = row;
         end
      end
      if (col + 1 < w) begin
         col_cnt = col + 1;
         return 1'b0;
      end
      col_cnt = 0;
      if (row + 1 < h) begin
         row_cnt = row + 1;
         return 1'b0;
      end
      if (trk_seen) begin
         mnc = trk_min_col;
         mxc = trk_max_col;
         mnr = trk_min_row;
         mxr = trk_max_row;
      end else begin
         mnc = w;
         mxc = 0;
         mnr = h;
         mxr = 0;
      end
      res.left_ext   = extent(longint'(mnc), longint'(w), 1'b0);
      res.right_ext  = extent(longint'(mxc + 1), longint'(w), 1'b1);
      res.top_ext    = extent(longint'(mnr), longint'(h), 1'b0);
      res.bottom_ext = extent(longint'(mxr + 1), longint'(h), 1'b1);
      res.min_col    = mnc[DIM_W-1:0];
      res.max_col    = mxc[BOX_MAX_W-1:0];
      res.min_row    = mnr[DIM_W-1:0];
      res.max_row    = mxr[BOX_MAX_W-1:0];
      res.all_clear  = !trk_seen;
      restart_tracking();
      return 1'b1;
   endfunction

   function automatic box_result_type mk_box(
      input logic [EXTENT_W-1:0] l, r, t, b,
      input int mnc, mxc, mnr, mxr,
      input logic clear
   );
      box_result_type res;
      res.left_ext   = l;
      res.right_ext  = r;
      res.top_ext    = t;
      res.bottom_ext = b;
      res.min_col    = mnc[DIM_W-1:0];
      res.max_col    = mxc[BOX_MAX_W-1:0];
      res.min_row    = mnr[DIM_W-1:0];
      res.max_row    = mxr[BOX_MAX_W-1:0];
      res.all_clear  = clear;
      return res;
   endfunction

   task automatic add_row(input row_op_type op, input int value, input bit typed,
                          input box_result_type res);
      stim_row_type row;
      row.op     = op;
      row.value  = value[DIM_W-1:0];
      row.typed  = typed;
      row.result = res;
      directed_rows.push_back(row);
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, name, want_v, got_v);
         mismatches++;
      end
   endtask

   // receiver: random stall, compare each result against the oldest prediction
   always @(posedge clock) begin : rsp_check
      box_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_boxes.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual 0x%0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_boxes.pop_front();
               check_field("left_extent",   32'(want.left_ext),   32'(rsp_tdata[16:0]));
               check_field("right_extent",  32'(want.right_ext),  32'(rsp_tdata[33:17]));
               check_field("top_extent",    32'(want.top_ext),    32'(rsp_tdata[50:34]));
               check_field("bottom_extent", 32'(want.bottom_ext), 32'(rsp_tdata[67:51]));
               check_field("box_min_col",   32'(want.min_col),    32'(rsp_tdata[80:68]));
               check_field("box_max_col",   32'(want.max_col),    32'(rsp_tdata[92:81]));
               check_field("box_min_row",   32'(want.min_row),    32'(rsp_tdata[105:93]));
               check_field("box_max_row",   32'(want.max_row),    32'(rsp_tdata[117:106]));
               check_field("padding",       32'd0,                32'(rsp_tdata[119:118]));
               check_field("all_clear",     32'(want.all_clear),  32'(rsp_tuser));
            end
         end
      end
   end

   // hold valid until the request is taken, then advance the predictor
   task automatic send_pixel(input logic [ALPHA_W-1:0] alpha, output bit done,
                             output box_result_type res);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= alpha;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      done = track_pixel(alpha, res);
      need_settle = 1'b1;
   endtask

   // write only once all results are out and any running division has drained
   task automatic set_reg(input logic [CSR_ADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      if (need_settle) repeat (SETTLE_CYCLES) @(posedge clock);
      need_settle = 1'b0;
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      if (addr == CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ALPHA_W-1:0] pick_alpha(input int density);
      case (density)
         0:       return '0;
         1:       return ($urandom_range(0, 7) == 0) ? ALPHA_W'($urandom_range(1, 255)) : '0;
         2:       return ($urandom_range(0, 1) == 0) ? ALPHA_W'($urandom_range(1, 255)) : '0;
         default: return ALPHA_W'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [DIM_W-1:0] pick_size(input int small_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return DIM_W'($urandom_range(13, 40));
      return DIM_W'($urandom_range(1, small_max));
   endfunction

   task automatic send_frame_pixels(input int count, input int density, input bit mark_last);
      int i;
      bit done;
      box_result_type res;
      for (i = 0; i < count; i++) begin
         send_pixel((mark_last && i == count - 1) ? ALPHA_W'($urandom_range(1, 255))
                                                  : pick_alpha(density), done, res);
         if (done) pending_boxes.push_back(res);
      end
   endtask

   task automatic run_frames(input int budget);
      int sent, n, cut;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 60) begin
            set_reg(CSR_IMAGE_WIDTH, pick_size(8));
            set_reg(CSR_IMAGE_HEIGHT, pick_size(6));
         end
         n = eff_dim(cfg_width) * eff_dim(cfg_height);
         if ($urandom_range(0, 9) == 0) begin
            // broken frame: resize partway, counters may now sit past the new size
            cut = $urandom_range(1, n);
            send_frame_pixels(cut, $urandom_range(0, 3), 1'b0);
            if ($urandom_range(0, 1) == 0)
               set_reg(CSR_IMAGE_WIDTH, DIM_W'($urandom_range(0, 8)));
            else
               set_reg(CSR_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 6)));
            sent += cut;
         end else begin
            send_frame_pixels(n, $urandom_range(0, 3), 1'b0);
            sent += n;
         end
      end
   endtask

   initial begin : stimulus
      int k, phase;
      bit done;
      box_result_type res;
      int tx_pcts[4];
      int rx_pcts[4];

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      need_settle  = 1'b0;
      cfg_width    = DIM_RESET;
      cfg_height   = DIM_RESET;
      restart_tracking();
      tx_pcts = '{0, 76, 0, 21};
      rx_pcts = '{0, 0, 76, 21};

      // zero sizes act as 1x1: every pixel is a frame
      add_row(OP_WIDTH, 0, 1'b0, '0);
      add_row(OP_HEIGHT, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b1, mk_box(EXT_NEG_HALF, EXT_POS_HALF, EXT_NEG_HALF,
                                        EXT_POS_HALF, 1, 0, 1, 0, 1'b1));
      add_row(OP_PIXEL, 255, 1'b1, mk_box(EXT_POS_HALF, EXT_POS_HALF, EXT_POS_HALF,
                                          EXT_POS_HALF, 0, 0, 0, 0, 1'b0));
      add_row(OP_PIXEL, 1, 1'b1, mk_box(EXT_POS_HALF, EXT_POS_HALF, EXT_POS_HALF,
                                        EXT_POS_HALF, 0, 0, 0, 0, 1'b0));
      add_row(OP_PIXEL, 128, 1'b0, '0);
      // 3x2 with one colored pixel
      add_row(OP_WIDTH, 3, 1'b0, '0);
      add_row(OP_HEIGHT, 2, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 7, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      // all-transparent 2x2
      add_row(OP_WIDTH, 2, 1'b0, '0);
      add_row(OP_HEIGHT, 2, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b1, mk_box(EXT_NEG_HALF, EXT_ZERO, EXT_NEG_HALF, EXT_ZERO,
                                        2, 0, 2, 0, 1'b1));
      // width shrinks mid-frame, box ends up outside the new width
      add_row(OP_WIDTH, 4, 1'b0, '0);
      add_row(OP_HEIGHT, 2, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 9, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_WIDTH, 2, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      // height shrinks mid-frame
      add_row(OP_WIDTH, 1, 1'b0, '0);
      add_row(OP_HEIGHT, 4, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_PIXEL, 0, 1'b0, '0);
      add_row(OP_HEIGHT, 1, 1'b0, '0);
      add_row(OP_PIXEL, 200, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < directed_rows.size(); k++) begin
         case (directed_rows[k].op)
            OP_WIDTH:  set_reg(CSR_IMAGE_WIDTH, directed_rows[k].value);
            OP_HEIGHT: set_reg(CSR_IMAGE_HEIGHT, directed_rows[k].value);
            default: begin
               send_pixel(directed_rows[k].value[ALPHA_W-1:0], done, res);
               if (done)
                  pending_boxes.push_back(directed_rows[k].typed ? directed_rows[k].result
                                                                 : res);
            end
         endcase
      end

      // saturating register values, then shrink to close the frame far past the new size
      set_reg(CSR_IMAGE_WIDTH, 13'd8191);
      set_reg(CSR_IMAGE_HEIGHT, 13'd1);
      send_frame_pixels(40, 1, 1'b1);
      set_reg(CSR_IMAGE_WIDTH, 13'd4);
      send_frame_pixels(1, 0, 1'b0);
      set_reg(CSR_IMAGE_WIDTH, 13'd1);
      set_reg(CSR_IMAGE_HEIGHT, DIM_W'($urandom_range(4097, 8190)));
      send_frame_pixels(30, 2, 1'b1);
      set_reg(CSR_IMAGE_HEIGHT, 13'd0);
      send_frame_pixels(1, 0, 1'b0);

      for (phase = 0; phase < 4; phase++) begin
         tx_idle_pct  = tx_pcts[phase];
         rx_stall_pct = rx_pcts[phase];
         run_frames(225);
      end

      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/abbx_pkg.sv
hw/rtl/abbx_tracker.sv
hw/rtl/abbx_divider.sv
hw/rtl/alpha_bounding_box_extents_unit.sv
tb/testbench.sv
